// ===== rtl/core/cse_pkg.sv =====
// ----------------------------------------------------------------------------
// cse_pkg
// Types, constants and helpers shared by the cubic spline segment evaluator.
// ----------------------------------------------------------------------------
package cse_pkg;

  localparam logic [16:0] POS_ONE    = 17'd65536;
  localparam int          POS_W      = 17;
  localparam int          R_QB       = 37;  // quotient bits of the slope ratio
  localparam int          I_QB       = 32;  // quotient bits of the integral
  localparam int          PROD_W     = 63;  // magnitude of slope * spacing
  localparam int          SPC_W      = 31;
  localparam int          DEN2_W     = 35;  // 12 * scale
  localparam int          V_W        = 40;  // rounded sum
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic              sat;
    logic signed [31:0] val;
  } cse_sat_t;

  // side data that rides along the slope ratio divider
  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [32:0] df;
    logic               cden;
    logic               integ;
    logic [SPC_W-1:0]   scale;
    logic [POS_W-1:0]   tu;
    logic [POS_W-1:0]   td;
    logic [POS_W-1:0]   pu2;
    logic [POS_W-1:0]   pd2;
    logic               neg;
  } cse_side1_t;

  // side data that rides along the integral divider
  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
    logic signed [31:0] d;
    logic               sat;
    logic               integ;
    logic               neg;
    logic signed [31:0] res_val;
    logic               val_sat;
  } cse_side2_t;

  function automatic cse_sat_t sat32(input logic signed [63:0] v);
    cse_sat_t o;
    if (v > 64'(S32_MAX)) begin
      o.sat = 1'b1;
      o.val = S32_MAX;
    end else if (v < 64'(S32_MIN)) begin
      o.sat = 1'b1;
      o.val = S32_MIN;
    end else begin
      o.sat = 1'b0;
      o.val = v[31:0];
    end
    return o;
  endfunction

  // Q1.16 product of two Q1.16 values, rounded half up back to Q1.16
  function automatic logic [POS_W-1:0] rnd16(input logic [33:0] p);
    return POS_W'((p + 34'd32768) >> 16);
  endfunction

endpackage

// ===== rtl/core/cse_div.sv =====
// ----------------------------------------------------------------------------
// cse_div
// Pipelined restoring divider, one quotient bit per stage, with overflow flag
// when the quotient does not fit in Q_W bits. Side data travels alongside.
// ----------------------------------------------------------------------------
module cse_div #(
  parameter int NUM_W  = 63,
  parameter int DEN_W  = 31,
  parameter int Q_W    = 37,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_vld,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_vld,
  output logic [Q_W-1:0]    out_quo,
  output logic              out_ovf,
  output logic [SIDE_W-1:0] out_side
);
  localparam int XW = NUM_W + DEN_W + Q_W;

  logic              vld   [0:Q_W];
  logic [NUM_W-1:0]  rem   [0:Q_W];
  logic [DEN_W-1:0]  den   [0:Q_W];
  logic [Q_W-1:0]    quo   [0:Q_W];
  logic              ovf   [0:Q_W];
  logic [SIDE_W-1:0] side  [0:Q_W];
  logic [XW-1:0]     trial [1:Q_W];
  logic              take  [1:Q_W];

  always_comb begin
    for (int k = 1; k <= Q_W; k++) begin
      trial[k] = XW'(den[k-1]) << (Q_W - k);
      take[k]  = XW'(rem[k-1]) >= trial[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= Q_W; k++) vld[k] <= 1'b0;
    end else begin
      vld[0] <= in_vld;
      for (int k = 1; k <= Q_W; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    rem[0]  <= in_num;
    den[0]  <= in_den;
    quo[0]  <= '0;
    ovf[0]  <= XW'(in_num) >= (XW'(in_den) << Q_W);
    side[0] <= in_side;
    for (int k = 1; k <= Q_W; k++) begin
      den[k]  <= den[k-1];
      ovf[k]  <= ovf[k-1];
      side[k] <= side[k-1];
      if (take[k]) begin
        rem[k] <= NUM_W'(XW'(rem[k-1]) - trial[k]);
        quo[k] <= quo[k-1] | ({{(Q_W-1){1'b0}}, 1'b1} << (Q_W - k));
      end else begin
        rem[k] <= rem[k-1];
        quo[k] <= quo[k-1];
      end
    end
  end

  assign out_vld  = vld[Q_W];
  assign out_quo  = quo[Q_W];
  assign out_ovf  = ovf[Q_W];
  assign out_side = side[Q_W];

endmodule

// ===== rtl/core/cubic_spline_segment_eval_top.sv =====
// ----------------------------------------------------------------------------
// cubic_spline_segment_eval_top
// Evaluates one cubic spline segment per word: coefficients, then the value
// at the upper position or the scaled integral between the two positions.
// ----------------------------------------------------------------------------
//  channel  | handshake        | ports
//  ---------+------------------+-----------------------------------------------
//  input    | start & !busy    | value_low .. has_end
//  result   | done (1 cycle)   | result, coef_a .. coef_d, saturated
//
//  A word is taken every cycle; busy stays low. The result passes through the
//  two pipelined dividers (37 and 32 quotient bits, one per stage) plus the
//  multiply and rounding stages. Reset clears the valid bits of every stage.
//  The receiver cannot stall.
module cubic_spline_segment_eval_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] value_low,
  input  logic signed [31:0] value_high,
  input  logic signed [31:0] slope_low,
  input  logic signed [31:0] slope_high,
  input  logic [30:0]        spacing_low,
  input  logic [30:0]        spacing_high,
  input  logic [30:0]        scale_factor,
  input  logic [16:0]        pos_upper,
  input  logic [16:0]        pos_lower,
  input  logic               integrate,
  input  logic               has_start,
  input  logic               has_end,
  output logic               done,
  output logic signed [31:0] result,
  output logic signed [31:0] coef_a,
  output logic signed [31:0] coef_b,
  output logic signed [31:0] coef_c,
  output logic signed [31:0] coef_d,
  output logic               saturated
);
  import cse_pkg::*;

  localparam int RM_W   = R_QB + 1;
  localparam int NUM2_W = V_W + FRAC_BITS;
  localparam int LAT_V3 = 81;
  localparam int LAT_E2 = 41;

  // input stage
  logic               v1, v2, v3;
  logic signed [31:0] a1, b1, f1_1, s1_1;
  logic [SPC_W-1:0]   k0_1, k1_1, sc1;
  logic [POS_W-1:0]   tu1, td1;
  logic               integ1, cden1;

  // product stage
  logic signed [63:0] prod2;
  logic signed [32:0] df2;
  logic [33:0]        tusq2, tdsq2;
  logic signed [31:0] a2, b2;
  logic [SPC_W-1:0]   k0_2, sc2;
  logic [POS_W-1:0]   tu2, td2;
  logic               integ2, cden2;

  // divider feed
  logic [PROD_W-1:0]  mag3;
  logic [SPC_W-1:0]   k0_3;
  cse_side1_t         side3;

  logic               d1_vld, d1_ovf;
  logic [R_QB-1:0]    d1_quo;
  cse_side1_t         d1_side;

  logic               e1_v, e2_v, e3_v, e4_v, e5_v, e6_v, e7_v, e8_v, e9_v;
  cse_side1_t         e1_s, e2_s, e3_s, e4_s, e5_s, e6_s, e7_s, e8_s;
  logic signed [RM_W:0] e1_r;
  logic [RM_W-1:0]    rmag;
  logic [33:0]        e1_pu3raw, e1_pd3raw, e3_pu4raw, e3_pd4raw;
  logic signed [31:0] e2_c, e2_d, e3_c, e3_d, e4_c, e4_d;
  logic               e2_sat, e3_sat, e4_sat, e5_sat, e6_sat, e7_sat, e8_sat;
  logic [POS_W-1:0]   e2_pu3, e2_pd3, e3_pu3, e3_pd3, e4_pu3, e4_pd3, e4_pu4, e4_pd4;
  logic signed [40:0] cw, dw;
  cse_sat_t           c_sat, d_sat;

  logic signed [17:0] y0, y1, y2, y3;
  logic signed [49:0] p0, p1, p2, p3;
  logic signed [31:0] e5_c, e5_d, e6_c, e6_d, e7_c, e7_d, e8_c, e8_d;
  logic signed [54:0] w0, w1, w2, w3;
  logic signed [55:0] e7_sum;
  logic signed [V_W-1:0] e8_v_r;
  logic [V_W-1:0]     vmag;
  cse_sat_t           vsat;

  logic [NUM2_W-1:0]  e9_num;
  logic [DEN2_W-1:0]  e9_den;
  cse_side2_t         side9;

  logic               d2_vld, d2_ovf;
  logic [I_QB-1:0]    d2_quo;
  cse_side2_t         d2_side;
  cse_sat_t           isat;

  assign busy = 1'b0;

  // ---- valid bits ----
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
      e1_v <= 1'b0; e2_v <= 1'b0; e3_v <= 1'b0; e4_v <= 1'b0; e5_v <= 1'b0;
      e6_v <= 1'b0; e7_v <= 1'b0; e8_v <= 1'b0; e9_v <= 1'b0;
      done <= 1'b0;
    end else begin
      v1 <= start & ~busy; v2 <= v1; v3 <= v2;
      e1_v <= d1_vld; e2_v <= e1_v; e3_v <= e2_v; e4_v <= e3_v; e5_v <= e4_v;
      e6_v <= e5_v; e7_v <= e6_v; e8_v <= e7_v; e9_v <= e8_v;
      done <= d2_vld;
    end
  end

  // ---- front: operand capture, slope product, squares ----
  always_ff @(posedge clk) begin
    a1     <= has_start ? value_low : 32'sd0;
    b1     <= has_start ? slope_low : 32'sd0;
    f1_1   <= value_high;
    s1_1   <= slope_high;
    k0_1   <= (spacing_low == '0) ? SPC_W'(1) : spacing_low;
    k1_1   <= spacing_high;
    sc1    <= (scale_factor == '0) ? SPC_W'(1) : scale_factor;
    tu1    <= (pos_upper > POS_ONE) ? POS_ONE : pos_upper;
    td1    <= (pos_lower > POS_ONE) ? POS_ONE : pos_lower;
    integ1 <= integrate;
    cden1  <= has_start & has_end;

    prod2  <= s1_1 * $signed({1'b0, k1_1});
    df2    <= 33'(f1_1) - 33'(a1);
    tusq2  <= tu1 * tu1;
    tdsq2  <= td1 * td1;
    a2 <= a1; b2 <= b1; k0_2 <= k0_1; sc2 <= sc1;
    tu2 <= tu1; td2 <= td1; integ2 <= integ1; cden2 <= cden1;

    mag3        <= (prod2 < 0) ? PROD_W'(-prod2) : PROD_W'(prod2);
    k0_3        <= k0_2;
    side3.a     <= a2;
    side3.b     <= b2;
    side3.df    <= df2;
    side3.cden  <= cden2;
    side3.integ <= integ2;
    side3.scale <= sc2;
    side3.tu    <= tu2;
    side3.td    <= td2;
    side3.pu2   <= rnd16(tusq2);
    side3.pd2   <= rnd16(tdsq2);
    side3.neg   <= prod2 < 0;
  end

  cse_div #(
    .NUM_W (PROD_W),
    .DEN_W (SPC_W),
    .Q_W   (R_QB),
    .SIDE_W($bits(cse_side1_t))
  ) u_div_ratio (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (v3),
    .in_num  (mag3),
    .in_den  (k0_3),
    .in_side (side3),
    .out_vld (d1_vld),
    .out_quo (d1_quo),
    .out_ovf (d1_ovf),
    .out_side(d1_side)
  );

  // an oversized ratio is pinned well past the clamp limits of C and D
  assign rmag = d1_ovf ? (RM_W'(1) << R_QB) : RM_W'(d1_quo);

  always_comb begin
    cw    = (41'(e1_s.df) <<< 1) + 41'(e1_s.df) - (41'(e1_s.b) <<< 1) - 41'(e1_r);
    dw    = 41'(e1_s.b) + 41'(e1_r) - (41'(e1_s.df) <<< 1);
    c_sat = sat32(64'(cw));
    d_sat = sat32(64'(dw));
  end

  always_comb begin
    if (e4_s.integ) begin
      y0 = $signed({1'b0, e4_s.tu})  - $signed({1'b0, e4_s.td});
      y1 = $signed({1'b0, e4_s.pu2}) - $signed({1'b0, e4_s.pd2});
      y2 = $signed({1'b0, e4_pu3})   - $signed({1'b0, e4_pd3});
      y3 = $signed({1'b0, e4_pu4})   - $signed({1'b0, e4_pd4});
    end else begin
      y0 = $signed({1'b0, POS_ONE});
      y1 = $signed({1'b0, e4_s.tu});
      y2 = $signed({1'b0, e4_s.pu2});
      y3 = $signed({1'b0, e4_pu3});
    end
  end

  always_comb begin
    vsat = sat32(64'(e8_v_r));
    vmag = (e8_v_r < 0) ? V_W'(-e8_v_r) : V_W'(e8_v_r);
  end

  // ---- back: C/D, higher powers, products, sum, rounding ----
  always_ff @(posedge clk) begin
    e1_s      <= d1_side;
    e1_r      <= d1_side.neg ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
    e1_pu3raw <= d1_side.pu2 * d1_side.tu;
    e1_pd3raw <= d1_side.pd2 * d1_side.td;

    e2_s   <= e1_s;
    e2_c   <= e1_s.cden ? c_sat.val : 32'sd0;
    e2_d   <= e1_s.cden ? d_sat.val : 32'sd0;
    e2_sat <= e1_s.cden & (c_sat.sat | d_sat.sat);
    e2_pu3 <= rnd16(e1_pu3raw);
    e2_pd3 <= rnd16(e1_pd3raw);

    e3_s <= e2_s; e3_c <= e2_c; e3_d <= e2_d; e3_sat <= e2_sat;
    e3_pu3 <= e2_pu3; e3_pd3 <= e2_pd3;
    e3_pu4raw <= e2_pu3 * e2_s.tu;
    e3_pd4raw <= e2_pd3 * e2_s.td;

    e4_s <= e3_s; e4_c <= e3_c; e4_d <= e3_d; e4_sat <= e3_sat;
    e4_pu3 <= e3_pu3; e4_pd3 <= e3_pd3;
    e4_pu4 <= rnd16(e3_pu4raw);
    e4_pd4 <= rnd16(e3_pd4raw);

    e5_s <= e4_s; e5_c <= e4_c; e5_d <= e4_d; e5_sat <= e4_sat;
    p0 <= e4_s.a * y0;
    p1 <= e4_s.b * y1;
    p2 <= e4_c * y2;
    p3 <= e4_d * y3;

    // integral weights 12, 6, 4, 3 over a common factor of 12
    e6_s <= e5_s; e6_c <= e5_c; e6_d <= e5_d; e6_sat <= e5_sat;
    w0 <= e5_s.integ ? 55'(p0) * 55'sd12 : 55'(p0);
    w1 <= e5_s.integ ? 55'(p1) * 55'sd6  : 55'(p1);
    w2 <= e5_s.integ ? 55'(p2) * 55'sd4  : 55'(p2);
    w3 <= e5_s.integ ? 55'(p3) * 55'sd3  : 55'(p3);

    e7_s <= e6_s; e7_c <= e6_c; e7_d <= e6_d; e7_sat <= e6_sat;
    e7_sum <= 56'(w0) + 56'(w1) + 56'(w2) + 56'(w3);

    e8_s <= e7_s; e8_c <= e7_c; e8_d <= e7_d; e8_sat <= e7_sat;
    e8_v_r <= V_W'((e7_sum + 56'sd32768) >>> 16);

    e9_num        <= NUM2_W'(vmag) << FRAC_BITS;
    e9_den        <= DEN2_W'(e8_s.scale) * DEN2_W'(12);
    side9.a       <= e8_s.a;
    side9.b       <= e8_s.b;
    side9.c       <= e8_c;
    side9.d       <= e8_d;
    side9.sat     <= e8_sat;
    side9.integ   <= e8_s.integ;
    side9.neg     <= e8_v_r < 0;
    side9.res_val <= vsat.val;
    side9.val_sat <= vsat.sat;
  end

  cse_div #(
    .NUM_W (NUM2_W),
    .DEN_W (DEN2_W),
    .Q_W   (I_QB),
    .SIDE_W($bits(cse_side2_t))
  ) u_div_scale (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (e9_v),
    .in_num  (e9_num),
    .in_den  (e9_den),
    .in_side (side9),
    .out_vld (d2_vld),
    .out_quo (d2_quo),
    .out_ovf (d2_ovf),
    .out_side(d2_side)
  );

  always_comb begin
    isat = sat32(d2_side.neg ? -$signed({32'd0, d2_quo}) : $signed({32'd0, d2_quo}));
  end

  always_ff @(posedge clk) begin
    coef_a <= d2_side.a;
    coef_b <= d2_side.b;
    coef_c <= d2_side.c;
    coef_d <= d2_side.d;
    if (!d2_side.integ) begin
      result    <= d2_side.res_val;
      saturated <= d2_side.sat | d2_side.val_sat;
    end else if (d2_ovf) begin
      result    <= d2_side.neg ? S32_MIN : S32_MAX;
      saturated <= 1'b1;
    end else begin
      result    <= isat.val;
      saturated <= d2_side.sat | isat.sat;
    end
  end

  // ---- checks ----
  a_lat: assert property (@(posedge clk) disable iff (rst) v3 |-> ##LAT_V3 done)
    else $error("word lost between divider feed and output");

  a_cd_sat: assert property (@(posedge clk) disable iff (rst)
    e2_v && e2_sat |-> ##LAT_E2 (done && saturated))
    else $error("coefficient clamp not reported");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    done && coef_a == 0 && coef_b == 0 && coef_c == 0 && coef_d == 0
    |-> result == 0 && !saturated)
    else $error("nonzero result from zero cubic");

endmodule
